@@ hw/rtl/dogx_pkg.sv @@
`default_nettype none

package dogx_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int WREG_BITS   = 11;
    localparam int HREG_BITS   = 13;
    localparam int CFG_BITS    = 13;
    localparam int SCALE_COUNT = 3;

    // register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WREG_BITS-1:0] WIDTH_RESET  = WREG_BITS'(640);
    localparam logic [HREG_BITS-1:0] HEIGHT_RESET = HREG_BITS'(480);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // index 0 = finer scale, 1 = scale under test, 2 = coarser scale
    typedef sample_t [SCALE_COUNT-1:0] scale_trio_t;

    typedef struct packed {
        logic    frame_start;
        sample_t dog_below;
        sample_t dog_center;
        sample_t dog_above;
    } pixel_in_t;

    typedef struct packed {
        logic        is_keypoint;
        logic [9:0]  center_x;
        logic [11:0] center_y;
        logic        frame_last;
    } result_t;

    // which window rows/columns lie inside the interior of the frame
    typedef struct packed {
        logic row_top_ok;
        logic row_bot_ok;
        logic col_left_ok;
        logic col_right_ok;
    } nbr_mask_t;

endpackage

`default_nettype wire

@@ hw/rtl/dogx_line_buffer.sv @@
`default_nettype none

module dogx_line_buffer (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                rd_en,
    input  wire  [dogx_pkg::COL_BITS-1:0]      rd_addr,
    input  wire                                wr_en,
    input  wire  [dogx_pkg::COL_BITS-1:0]      wr_addr,
    input  dogx_pkg::scale_trio_t              wr_upper,
    input  dogx_pkg::scale_trio_t              wr_middle,
    output dogx_pkg::scale_trio_t              rd_upper,
    output dogx_pkg::scale_trio_t              rd_middle
);
    import dogx_pkg::*;

    scale_trio_t upper_mem  [MAX_WIDTH];
    scale_trio_t middle_mem [MAX_WIDTH];

    scale_trio_t upper_q_reg;
    scale_trio_t middle_q_reg;
    scale_trio_t fwd_upper_reg;
    scale_trio_t fwd_middle_reg;
    logic        fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
        if (rd_en)
        begin
            upper_q_reg    <= upper_mem[rd_addr];
            middle_q_reg   <= middle_mem[rd_addr];
            fwd_upper_reg  <= wr_upper;
            fwd_middle_reg <= wr_middle;
        end
    end

    // read and write of the same column in one cycle: take the new data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_hit_reg <= 1'b0;
        else if (rd_en)
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign rd_upper  = fwd_hit_reg ? fwd_upper_reg  : upper_q_reg;
    assign rd_middle = fwd_hit_reg ? fwd_middle_reg : middle_q_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dogx_window.sv @@
`default_nettype none

module dogx_window (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    shift_en,
    input  dogx_pkg::scale_trio_t  col_upper,
    input  dogx_pkg::scale_trio_t  col_middle,
    input  dogx_pkg::scale_trio_t  col_new,
    input  dogx_pkg::nbr_mask_t    mask,
    output logic                   is_keypoint
);
    import dogx_pkg::*;

    sample_t    win_reg  [3][3][3];
    sample_t    win_next [3][3][3];
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    sample_t    ctr;
    logic       key;

    always_comb
    begin
        for (int s = 0; s < 3; s++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[s][r][0] = win_reg[s][r][1];
                win_next[s][r][1] = win_reg[s][r][2];
            end
            win_next[s][0][2] = sample_t'(col_upper[s]);
            win_next[s][1][2] = sample_t'(col_middle[s]);
            win_next[s][2][2] = sample_t'(col_new[s]);
        end
    end

    assign row_ok = {mask.row_bot_ok, 1'b1, mask.row_top_ok};
    assign col_ok = {mask.col_right_ok, 1'b1, mask.col_left_ok};
    assign ctr    = win_next[1][1][1];

    // strict max (ctr > 0) or min (ctr < 0) of interior neighbors; zero fails
    always_comb
    begin
        key = (ctr != '0);
        for (int s = 0; s < 3; s++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (row_ok[r] && col_ok[c] && !(s == 1 && r == 1 && c == 1))
                    begin
                        if ((!ctr[SAMPLE_BITS-1] && (ctr <= win_next[s][r][c])) ||
                            (ctr[SAMPLE_BITS-1] && (ctr >= win_next[s][r][c])))
                            key = 1'b0;
                    end
                end
            end
        end
    end

    assign is_keypoint = key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 3; s++)
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        win_reg[s][r][c] <= '0;
        end
        else if (shift_en)
        begin
            for (int s = 0; s < 3; s++)
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        win_reg[s][r][c] <= win_next[s][r][c];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dog_extremum_detector_unit.sv @@
// DoG 3x3x3 scale-space extremum detector. Pixels arrive in raster order on the
// pixel channel, one beat per pixel, each beat holding the samples of three
// adjacent scales. The block takes one beat per clock and sustains that rate
// while the result side does not stall. A result beat is offered once its
// pixel has passed the stage 1 registers (the line store read is registered
// when the pixel is accepted) and the result register, which the window shift
// and the 26 parallel compares load when stage 1 advances. A pixel at column
// x >= 2 and row y >= 2 produces one result beat for the center (x-1, y-1);
// other pixels produce none. The line stores are two single-port-read/
// single-port-write memories of 1024 x 48 bits, read when a pixel is accepted
// and written back when that pixel leaves stage 1 for the window, which waits
// while the result side stalls; a read meeting a same-column write is forwarded.
// They have no reset and need no clearing pass: every column read for a result
// has been written earlier in the same frame. frame_start restarts the
// position counters; a frame also restarts on its own after image_height rows.
// image_width is used clamped to [3, 1024], image_height to [3, 4096].
// Write the configuration registers only while the block is idle.
`default_nettype none

module dog_extremum_detector_unit (
    input  wire                             clk,
    input  wire                             rst_n,
    // pixel input
    input  wire                             pixel_valid,
    output logic                            pixel_ready,
    input  dogx_pkg::pixel_in_t             pixel,
    // result output
    output logic                            result_valid,
    input  wire                             result_ready,
    output dogx_pkg::result_t               result,
    // configuration writes
    input  wire                             cfg_we,
    input  wire                             cfg_index,
    input  wire  [dogx_pkg::CFG_BITS-1:0]   cfg_data
);
    import dogx_pkg::*;

    // configuration
    logic [WREG_BITS-1:0] width_reg;
    logic [HREG_BITS-1:0] height_reg;
    logic [WREG_BITS-1:0] w_eff;
    logic [HREG_BITS-1:0] h_eff;

    // position counters
    logic [COL_BITS-1:0]  col_reg;
    logic [COL_BITS-1:0]  col_next;
    logic [ROW_BITS-1:0]  row_reg;
    logic [ROW_BITS-1:0]  row_next;
    logic [COL_BITS-1:0]  x_cur;
    logic [ROW_BITS-1:0]  y_cur;
    logic [WREG_BITS-1:0] col_inc;
    logic [HREG_BITS-1:0] row_inc;

    // stage 1: pixel waiting for its line store read
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [COL_BITS-1:0]  s1_x_reg;
    logic [ROW_BITS-1:0]  s1_y_reg;
    scale_trio_t          s1_samp_reg;
    logic                 s1_has_res_reg;
    logic                 s1_last_reg;
    nbr_mask_t            s1_mask_reg;

    // result register
    logic                 res_valid_reg;
    logic                 res_valid_next;
    result_t              res_data_reg;

    logic                 accept;
    logic                 s1_advance;
    logic                 out_blocked;
    scale_trio_t          rd_upper;
    scale_trio_t          rd_middle;
    logic                 key;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WREG_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HREG_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // clamp to the supported frame geometry
    always_comb
    begin
        if (width_reg < WREG_BITS'(3))
            w_eff = WREG_BITS'(3);
        else if (width_reg > WREG_BITS'(MAX_WIDTH))
            w_eff = WREG_BITS'(MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg < HREG_BITS'(3))
            h_eff = HREG_BITS'(3);
        else if (height_reg > HREG_BITS'(MAX_HEIGHT))
            h_eff = HREG_BITS'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // ---------------- handshake ----------------
    // Stage 1 stalls only when the result register holds a beat nobody takes.
    assign out_blocked   = res_valid_reg && !result_ready;
    assign s1_advance    = s1_valid_reg && !out_blocked;
    assign pixel_ready   = !(s1_valid_reg && out_blocked);
    assign accept        = pixel_valid && pixel_ready;
    assign s1_valid_next = accept || (s1_valid_reg && !s1_advance);

    always_comb
    begin
        if (s1_advance && s1_has_res_reg)
            res_valid_next = 1'b1;
        else if (result_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    // ---------------- position of the incoming pixel ----------------
    always_comb
    begin
        if (pixel.frame_start || ({1'b0, col_reg} >= w_eff))
            x_cur = '0;
        else
            x_cur = col_reg;

        if (pixel.frame_start || ({1'b0, row_reg} >= h_eff))
            y_cur = '0;
        else
            y_cur = row_reg;

        col_inc = {1'b0, x_cur} + WREG_BITS'(1);
        row_inc = {1'b0, y_cur} + HREG_BITS'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_BITS-1:0];
            end
            else
            begin
                col_next = col_inc[COL_BITS-1:0];
                row_next = y_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // stage 1 payload; neighbor masks and the last-pixel flag are settled here
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg       <= x_cur;
            s1_y_reg       <= y_cur;
            s1_samp_reg    <= {pixel.dog_above, pixel.dog_center, pixel.dog_below};
            s1_has_res_reg <= (x_cur >= COL_BITS'(2)) && (y_cur >= ROW_BITS'(2));
            s1_last_reg    <= ({1'b0, x_cur} == (w_eff - WREG_BITS'(1))) &&
                              ({1'b0, y_cur} == (h_eff - HREG_BITS'(1)));
            s1_mask_reg.row_top_ok   <= (y_cur != ROW_BITS'(2));
            s1_mask_reg.row_bot_ok   <= ({1'b0, y_cur} != (h_eff - HREG_BITS'(1)));
            s1_mask_reg.col_left_ok  <= (x_cur != COL_BITS'(2));
            s1_mask_reg.col_right_ok <= ({1'b0, x_cur} != (w_eff - WREG_BITS'(1)));
        end
    end

    // ---------------- line stores ----------------
    // Upper row takes the old middle row, middle row takes the new pixel.
    dogx_line_buffer u_line_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr   (x_cur),
        .wr_en     (s1_advance),
        .wr_addr   (s1_x_reg),
        .wr_upper  (rd_middle),
        .wr_middle (s1_samp_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    // ---------------- window and compare ----------------
    dogx_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_en    (s1_advance),
        .col_upper   (rd_upper),
        .col_middle  (rd_middle),
        .col_new     (s1_samp_reg),
        .mask        (s1_mask_reg),
        .is_keypoint (key)
    );

    // ---------------- result register ----------------
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_has_res_reg)
        begin
            res_data_reg.is_keypoint <= key;
            res_data_reg.center_x    <= 10'(s1_x_reg - COL_BITS'(1));
            res_data_reg.center_y    <= 12'(s1_y_reg - ROW_BITS'(1));
            res_data_reg.frame_last  <= s1_last_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_data_reg;

endmodule

`default_nettype wire
